@@ hdl/pcfs_pkg.sv @@
// Shared types, channel constant tables and codes for the periodic CAN frame scheduler.
// Used by pcfs_frame, periodic_can_frame_scheduler and the testbench; depends on nothing.
package pcfs_pkg;

  localparam int TABLE_CH = 8;
  localparam logic [2:0] UART_CH = 3'd7;
  localparam logic [2:0] TEMP_CH = 3'd5;
  localparam logic [15:0] TEMP_OFFSET = 16'd40;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [3:0] GEAR_TOP = 4'd10;

  localparam logic [1:0] KIND_CAN = 2'd0;
  localparam logic [1:0] KIND_UART = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [3:0] BTN_NEXT = 4'd4;
  localparam logic [3:0] BTN_DEC = 4'd5;
  localparam logic [3:0] BTN_INC = 4'd6;
  localparam logic [3:0] BTN_TOGGLE = 4'd7;

  typedef struct packed {
    logic [9:0]  count;
    logic [12:0] value;
    logic        enable;
  } chan_ent_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ch;
    logic [15:0] pgn;
    logic [63:0] payload;
    logic [7:0]  sbyte;
    logic [12:0] value;
    logic        en;
  } res_t;

  function automatic logic [9:0] rom_interval(input logic [2:0] ch);
    logic [9:0] r;
    unique case (ch)
      3'd0: r = 10'd50;
      3'd1: r = 10'd100;
      3'd2: r = 10'd1000;
      3'd3: r = 10'd500;
      3'd4: r = 10'd50;
      3'd5: r = 10'd1000;
      3'd6: r = 10'd500;
      3'd7: r = 10'd500;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rom_pgn(input logic [2:0] ch);
    logic [15:0] r;
    unique case (ch)
      3'd0: r = 16'hF004;
      3'd1: r = 16'hFEF2;
      3'd2: r = 16'hFEF7;
      3'd3: r = 16'hFEEF;
      3'd4: r = 16'hFE6C;
      3'd5: r = 16'hFEEE;
      3'd6: r = 16'hFEEF;
      3'd7: r = 16'h0000;
    endcase
    return r;
  endfunction

  // Resolution in quarter units
  function automatic logic [10:0] rom_resq(input logic [2:0] ch);
    logic [10:0] r;
    unique case (ch)
      3'd0: r = 11'd32;
      3'd1: r = 11'd80;
      3'd2: r = 11'd80;
      3'd3: r = 11'd10;
      3'd4: r = 11'd1024;
      3'd5: r = 11'd4;
      3'd6: r = 11'd1;
      3'd7: r = 11'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] rom_offset(input logic [2:0] ch);
    logic [2:0] r;
    unique case (ch)
      3'd0: r = 3'd3;
      3'd1: r = 3'd0;
      3'd2: r = 3'd6;
      3'd3: r = 3'd7;
      3'd4: r = 3'd6;
      3'd5: r = 3'd0;
      3'd6: r = 3'd3;
      3'd7: r = 3'd0;
    endcase
    return r;
  endfunction

  // High when the channel packs two bytes
  function automatic logic rom_two(input logic [2:0] ch);
    logic r;
    unique case (ch)
      3'd3, 3'd5, 3'd6: r = 1'b0;
      default:          r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] rom_init(input logic [2:0] ch);
    logic [12:0] r;
    unique case (ch)
      3'd0:    r = 13'd4000;
      3'd5:    r = 13'd140;
      3'd6:    r = 13'd1000;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] rom_min(input logic [2:0] ch);
    logic [12:0] r;
    unique case (ch)
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] rom_max(input logic [2:0] ch);
    logic [12:0] r;
    unique case (ch)
      3'd0: r = 13'd7000;
      3'd1: r = 13'd100;
      3'd2: r = 13'd100;
      3'd3: r = 13'd200;
      3'd4: r = 13'd320;
      3'd5: r = 13'd280;
      3'd6: r = 13'd1500;
      3'd7: r = 13'd20;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] rom_step(input logic [2:0] ch);
    logic [6:0] r;
    unique case (ch)
      3'd0: r = 7'd100;
      3'd1: r = 7'd1;
      3'd2: r = 7'd1;
      3'd3: r = 7'd2;
      3'd4: r = 7'd2;
      3'd5: r = 7'd10;
      3'd6: r = 7'd100;
      3'd7: r = 7'd2;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gear_byte(input logic [3:0] g);
    logic [7:0] r;
    unique case (g)
      4'd0:    r = 8'd1;
      4'd1:    r = 8'd2;
      4'd2:    r = 8'd4;
      4'd3:    r = 8'd8;
      4'd4:    r = 8'd16;
      4'd5:    r = 8'd32;
      4'd6:    r = 8'd64;
      4'd7:    r = 8'd193;
      4'd8:    r = 8'd194;
      4'd9:    r = 8'd196;
      default: r = 8'd200;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/pcfs_frame.sv @@
// Builds the transmit result of one firing channel: scaled CAN payload or UART gear byte.
// Depends on pcfs_pkg.
module pcfs_frame
  import pcfs_pkg::*;
(
  input  logic [2:0]  ch,
  input  logic [12:0] value,
  output res_t        res
);

  logic [23:0] prod;
  logic [15:0] scaled;
  logic [2:0]  off;
  logic [3:0]  off_hi;
  logic [11:0] gear_raw;
  logic [3:0]  gear_idx;
  logic [63:0] payload;

  assign prod = 24'(value) * 24'(rom_resq(ch));
  assign scaled = prod[18:3] + ((ch == TEMP_CH) ? TEMP_OFFSET : 16'd0);
  assign off = rom_offset(ch);
  assign off_hi = {1'b0, off} + 4'd1;
  assign gear_raw = value[12:1];
  assign gear_idx = (gear_raw > 12'(GEAR_TOP)) ? GEAR_TOP : gear_raw[3:0];

  // Place the low byte at the offset and, for two-byte channels, the high byte above it; fill the rest
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (3'(k) == off) begin
        payload[k*8 +: 8] = scaled[7:0];
      end else if (rom_two(ch) && (4'(k) == off_hi)) begin
        payload[k*8 +: 8] = scaled[15:8];
      end else begin
        payload[k*8 +: 8] = FILL_BYTE;
      end
    end
  end

  always_comb begin
    res = '0;
    res.ch = ch;
    if (ch == UART_CH) begin
      res.kind = KIND_UART;
      res.sbyte = gear_byte(gear_idx);
    end else begin
      res.kind = KIND_CAN;
      res.pgn = rom_pgn(ch);
      res.payload = payload;
    end
  end

endmodule

@@ hdl/periodic_can_frame_scheduler.sv @@
// Top level of the periodic CAN frame scheduler: channel state memory, sequencer, output stage.
// Depends on pcfs_pkg and pcfs_frame.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   operation, button_id, button_level
//   output   out        out_valid / out_ready result_kind .. enabled_flag, last_of_run
//
// A tick walks the channel memory one entry per cycle while the output does not stall it:
// the first read is issued from idle, then each active channel (min(NUM_CHANNELS, 8))
// gets one read/modify/write, then the held result is flushed. A button press reads the
// selected entry, writes its update and flushes a status result; a released or unknown
// button is taken in idle and dropped. Reset is synchronous; per-entry valid bits
// make a never-written entry read as its table value, so no clearing pass is needed.
// A full output register holds the walk when a second result must be handed over, and
// holds the flush step until the held result can go.
module periodic_can_frame_scheduler
  import pcfs_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  button_id,
  input  logic        button_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [2:0]  channel_index,
  output logic [15:0] group_number,
  output logic [63:0] frame_payload,
  output logic [7:0]  serial_byte,
  output logic [12:0] value_halves,
  output logic        enabled_flag,
  output logic        last_of_run
);

  localparam int ACT = (NUM_CHANNELS < TABLE_CH) ? NUM_CHANNELS : TABLE_CH;
  localparam int AW = (ACT > 1) ? $clog2(ACT) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ACT - 1);

  typedef enum logic [1:0] {IDLE, RUN, BTN, FLUSH} state_t;

  state_t          state;
  logic [AW-1:0]   idx;
  logic [2:0]      sel;
  logic [3:0]      btn;
  logic            pend_valid;
  res_t            pend;
  res_t            out;

  // Channel memory: one entry per active channel, read data registered
  chan_ent_t       mem [ACT];
  logic [ACT-1:0]  vld;
  chan_ent_t       rd_data;
  logic            rd_vld;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  chan_ent_t       wr_data;

  logic [2:0]      ch;
  chan_ent_t       cur;
  logic            fire;
  logic            emit;
  logic            out_free;
  logic            stall;
  logic            push;
  logic            push_last;
  res_t            tick_res;
  res_t            stat_res;

  logic            in_xfer;
  logic            btn_act;
  logic [2:0]      sel_safe;
  logic [3:0]      sel_inc;
  logic [2:0]      sel_wrap;
  logic [2:0]      target;
  logic [13:0]     inc_sum;
  logic [13:0]     dec_floor;
  logic [12:0]     new_value;
  logic            new_enable;

  assign in_ready = (state == IDLE);
  assign in_xfer = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Entry under evaluation; a never-written entry reads as its reset value
  assign ch = 3'(idx);
  always_comb begin
    if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur.count = '0;
      cur.value = rom_init(ch);
      cur.enable = 1'b1;
    end
  end

  pcfs_frame u_frame (
    .ch    (ch),
    .value (cur.value),
    .res   (tick_res)
  );

  // Button decode: next selection wraps at the active channel count
  assign btn_act = button_level && (button_id == BTN_NEXT || button_id == BTN_DEC ||
                                    button_id == BTN_INC || button_id == BTN_TOGGLE);
  assign sel_safe = (4'(sel) >= 4'(ACT)) ? 3'd0 : sel;
  assign sel_inc = 4'(sel) + 4'd1;
  assign sel_wrap = (sel_inc >= 4'(ACT)) ? 3'd0 : sel_inc[2:0];
  assign target = (button_id == BTN_NEXT) ? sel_wrap : sel_safe;

  // Step arithmetic for the selected channel, saturating at its limits
  assign inc_sum = 14'(cur.value) + 14'(rom_step(ch));
  assign dec_floor = 14'(rom_min(ch)) + 14'(rom_step(ch));
  always_comb begin
    new_value = cur.value;
    new_enable = cur.enable;
    unique case (btn)
      BTN_DEC: begin
        if (cur.value > rom_min(ch)) begin
          new_value = (14'(cur.value) >= dec_floor) ? 13'(14'(cur.value) - 14'(rom_step(ch)))
                                                    : rom_min(ch);
        end
      end
      BTN_INC: begin
        if (cur.value < rom_max(ch)) begin
          new_value = (inc_sum > 14'(rom_max(ch))) ? rom_max(ch) : inc_sum[12:0];
        end
      end
      BTN_TOGGLE: new_enable = !cur.enable;
      default: ;
    endcase
  end

  always_comb begin
    stat_res = '0;
    stat_res.kind = KIND_STATUS;
    stat_res.ch = ch;
    stat_res.value = new_value;
    stat_res.en = new_enable;
  end

  assign fire = (cur.count == rom_interval(ch));
  assign emit = fire && cur.enable;
  // Hold the walk when a second result needs the output register while it is full
  assign stall = (state == RUN) && emit && pend_valid && !out_free;

  // Memory control: the walk writes entry idx while reading idx + 1, never the same entry
  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = cur;
    push = 1'b0;
    push_last = 1'b0;
    unique case (state)
      IDLE: begin
        if (in_xfer) begin
          if (!operation) begin
            rd_en = 1'b1;
          end else if (btn_act) begin
            rd_en = 1'b1;
            rd_addr = AW'(target);
          end
        end
      end
      RUN: begin
        if (!stall) begin
          wr_en = 1'b1;
          wr_data.count = fire ? 10'd0 : cur.count + 10'd1;
          push = emit && pend_valid;
          if (idx != LAST_IDX) begin
            rd_en = 1'b1;
            rd_addr = idx + AW'(1);
          end
        end
      end
      BTN: begin
        wr_en = 1'b1;
        wr_data.value = new_value;
        wr_data.enable = new_enable;
      end
      FLUSH: begin
        push = pend_valid && out_free;
        push_last = push;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // Sequencer, held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx <= '0;
      sel <= '0;
      btn <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      last_of_run <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
        out <= pend;
        last_of_run <= push_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            if (!operation) begin
              idx <= '0;
              state <= RUN;
            end else if (btn_act) begin
              idx <= AW'(target);
              btn <= button_id;
              if (button_id == BTN_NEXT) begin
                sel <= sel_wrap;
              end
              state <= BTN;
            end
          end
        end
        RUN: begin
          if (!stall) begin
            // Keep the newest result back so the last one can be marked
            if (emit) begin
              pend <= tick_res;
              pend_valid <= 1'b1;
            end
            if (idx == LAST_IDX) begin
              state <= FLUSH;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        BTN: begin
          pend <= stat_res;
          pend_valid <= 1'b1;
          state <= FLUSH;
        end
        FLUSH: begin
          if (!pend_valid) begin
            state <= IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state <= IDLE;
          end
        end
      endcase
    end
  end

  assign result_kind = out.kind;
  assign channel_index = out.ch;
  assign group_number = out.pgn;
  assign frame_payload = out.payload;
  assign serial_byte = out.sbyte;
  assign value_halves = out.value;
  assign enabled_flag = out.en;

  // No held result survives into a new transfer
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !pend_valid)
    else $error("held result left over at idle");

  // Read and write never hit the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write on the same entry");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("output register overwritten");

  // A button update always goes straight to the flush step
  a_btn_flush: assert property (@(posedge clk) disable iff (rst)
    (state == BTN) |=> (state == FLUSH))
    else $error("button update did not flush");

endmodule

@@ verif/tb_periodic_can_frame_scheduler.sv @@
// Self-checking testbench for periodic_can_frame_scheduler: a directed table of ticks and
// button events, then random tick runs and button sequences scored by an in-bench model.
// Depends on pcfs_pkg (codes, channel ids) and the scheduler RTL; reads no files.
module tb_periodic_can_frame_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import pcfs_pkg::*;

  localparam int NUM_CH = 8;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BUTTON = 1'b1;
  localparam logic LVL_RELEASE = 1'b0;
  localparam logic LVL_PRESS = 1'b1;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_ITEMS = 370;      // input transfers in the whole run
  localparam int DRAIN_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;    // margin for a final tick walk plus output hand-off

  // Per-channel description, kept in the bench independently of the RTL tables.
  typedef struct packed {
    logic [9:0]  period;
    logic [15:0] pgn;
    logic [10:0] resq;
    logic [2:0]  offset;
    logic [1:0]  nbytes;
    logic [12:0] start_h;
    logic [12:0] lo_h;
    logic [12:0] hi_h;
    logic [6:0]  stride;
  } chan_desc_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ch;
    logic [15:0] pgn;
    logic [63:0] data;
    logic [7:0]  sbyte;
    logic [12:0] halves;
    logic        en;
    logic        last;
  } out_rec_t;

  // One stimulus row; typed rows carry their own expected status (or none at all).
  typedef struct packed {
    logic        op;
    logic [3:0]  id;
    logic        lvl;
    logic        typed;
    logic        status_due;
    logic [2:0]  ch;
    logic [12:0] halves;
    logic        en;
  } stim_row_t;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_COIN, FLOW_SPARSE} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_TICK;
  logic [3:0]  button_id = 4'd0;
  logic        button_level = LVL_RELEASE;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [2:0]  channel_index;
  logic [15:0] group_number;
  logic [63:0] frame_payload;
  logic [7:0]  serial_byte;
  logic [12:0] value_halves;
  logic        enabled_flag;
  logic        last_of_run;

  // Scheduler model state
  logic [9:0]  tick_count [NUM_CH];
  logic [12:0] chan_value [NUM_CH];
  logic        chan_on [NUM_CH];
  logic [2:0]  sel_ch;
  int          rollovers [NUM_CH];

  out_rec_t    step_out [$];     // results caused by the event just applied
  out_rec_t    due_outputs [$];  // results still owed by the block, oldest first

  int burst_left;
  int gap_len;
  int errors = 0;
  int n_items = 0;
  int n_ticks = 0;
  int n_presses = 0;
  int n_can = 0;
  int n_uart = 0;
  int n_status = 0;

  // Directed table: typed expectations come straight from the reset state.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_TICK,   4'd0,       LVL_RELEASE, 1'b1, 1'b0, 3'd0, 13'd0,    1'b0}, // counters at 0
    '{OP_BUTTON, BTN_INC,    LVL_RELEASE, 1'b1, 1'b0, 3'd0, 13'd0,    1'b0}, // release ignored
    '{OP_BUTTON, 4'd0,       LVL_PRESS,   1'b1, 1'b0, 3'd0, 13'd0,    1'b0}, // unknown ids
    '{OP_BUTTON, 4'd3,       LVL_PRESS,   1'b1, 1'b0, 3'd0, 13'd0,    1'b0},
    '{OP_BUTTON, 4'd8,       LVL_PRESS,   1'b1, 1'b0, 3'd0, 13'd0,    1'b0},
    '{OP_BUTTON, 4'd15,      LVL_PRESS,   1'b1, 1'b0, 3'd0, 13'd0,    1'b0},
    '{OP_BUTTON, 4'd15,      LVL_RELEASE, 1'b1, 1'b0, 3'd0, 13'd0,    1'b0},
    '{OP_BUTTON, BTN_INC,    LVL_PRESS,   1'b1, 1'b1, 3'd0, 13'd4100, 1'b1},
    '{OP_BUTTON, BTN_DEC,    LVL_PRESS,   1'b1, 1'b1, 3'd0, 13'd4000, 1'b1},
    '{OP_BUTTON, BTN_TOGGLE, LVL_PRESS,   1'b1, 1'b1, 3'd0, 13'd4000, 1'b0},
    '{OP_BUTTON, BTN_TOGGLE, LVL_PRESS,   1'b1, 1'b1, 3'd0, 13'd4000, 1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd1, 13'd0,    1'b1},
    '{OP_BUTTON, BTN_DEC,    LVL_PRESS,   1'b1, 1'b1, 3'd1, 13'd0,    1'b1}, // held at min
    '{OP_BUTTON, BTN_INC,    LVL_PRESS,   1'b1, 1'b1, 3'd1, 13'd1,    1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd2, 13'd0,    1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd3, 13'd0,    1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd4, 13'd0,    1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd5, 13'd140,  1'b1},
    '{OP_BUTTON, BTN_DEC,    LVL_PRESS,   1'b1, 1'b1, 3'd5, 13'd130,  1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd6, 13'd1000, 1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd7, 13'd0,    1'b1},
    '{OP_BUTTON, BTN_INC,    LVL_PRESS,   1'b1, 1'b1, 3'd7, 13'd2,    1'b1},
    '{OP_BUTTON, BTN_NEXT,   LVL_PRESS,   1'b1, 1'b1, 3'd0, 13'd4000, 1'b1}, // selection wraps
    '{OP_TICK,   4'd15,      LVL_PRESS,   1'b0, 1'b0, 3'd0, 13'd0,    1'b0}, // tick ignores id
    '{OP_TICK,   BTN_TOGGLE, LVL_PRESS,   1'b0, 1'b0, 3'd0, 13'd0,    1'b0}
  };

  periodic_can_frame_scheduler #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .button_id    (button_id),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .channel_index(channel_index),
    .group_number (group_number),
    .frame_payload(frame_payload),
    .serial_byte  (serial_byte),
    .value_halves (value_halves),
    .enabled_flag (enabled_flag),
    .last_of_run  (last_of_run)
  );

  always #10 clk = ~clk;

  function automatic chan_desc_t chan_desc(input logic [2:0] ch);
    chan_desc_t d;
    case (ch)
      3'd0:    d = '{10'd50,   16'hF004, 11'd32,   3'd3, 2'd2, 13'd4000, 13'd0, 13'd7000, 7'd100};
      3'd1:    d = '{10'd100,  16'hFEF2, 11'd80,   3'd0, 2'd2, 13'd0,    13'd0, 13'd100,  7'd1};
      3'd2:    d = '{10'd1000, 16'hFEF7, 11'd80,   3'd6, 2'd2, 13'd0,    13'd0, 13'd100,  7'd1};
      3'd3:    d = '{10'd500,  16'hFEEF, 11'd10,   3'd7, 2'd1, 13'd0,    13'd0, 13'd200,  7'd2};
      3'd4:    d = '{10'd50,   16'hFE6C, 11'd1024, 3'd6, 2'd2, 13'd0,    13'd0, 13'd320,  7'd2};
      3'd5:    d = '{10'd1000, 16'hFEEE, 11'd4,    3'd0, 2'd1, 13'd140,  13'd0, 13'd280,  7'd10};
      3'd6:    d = '{10'd500,  16'hFEEF, 11'd1,    3'd3, 2'd1, 13'd1000, 13'd0, 13'd1500, 7'd100};
      default: d = '{10'd500,  16'h0000, 11'd4,    3'd0, 2'd2, 13'd0,    13'd0, 13'd20,   7'd2};
    endcase
    return d;
  endfunction

  function automatic logic [7:0] gear_code(input logic [12:0] g);
    logic [7:0] code;
    case (g)
      13'd0:   code = 8'd1;
      13'd1:   code = 8'd2;
      13'd2:   code = 8'd4;
      13'd3:   code = 8'd8;
      13'd4:   code = 8'd16;
      13'd5:   code = 8'd32;
      13'd6:   code = 8'd64;
      13'd7:   code = 8'd193;
      13'd8:   code = 8'd194;
      13'd9:   code = 8'd196;
      default: code = 8'd200;
    endcase
    return code;
  endfunction

  // CAN data: all bytes 0xFF, then the scaled value dropped in little-endian at the offset.
  function automatic logic [63:0] can_data(input logic [2:0] ch);
    chan_desc_t  d;
    logic [31:0] scaled;
    logic [63:0] data;
    d = chan_desc(ch);
    scaled = (32'(chan_value[ch]) * 32'(d.resq)) >> 3;
    if (ch == TEMP_CH) scaled = scaled + 32'(TEMP_OFFSET);
    data = {8{FILL_BYTE}};
    for (int b = 0; b < int'(d.nbytes); b++) begin
      if (int'(d.offset) + b < 8) data[(int'(d.offset) + b) * 8 +: 8] = scaled[8 * b +: 8];
    end
    return data;
  endfunction

  function automatic void reset_scheduler();
    for (int i = 0; i < NUM_CH; i++) begin
      tick_count[i] = '0;
      chan_value[i] = chan_desc(3'(i)).start_h;
      chan_on[i] = 1'b1;
      rollovers[i] = 0;
    end
    sel_ch = '0;
  endfunction

  // Apply one accepted event to the model; leave the results it causes in step_out.
  function automatic void schedule_event(input logic op, input logic [3:0] id,
                                         input logic lvl);
    chan_desc_t  d;
    out_rec_t    rec;
    logic [2:0]  s;
    logic [13:0] sum;
    step_out.delete();
    if (op == OP_TICK) begin
      // Visit channels in index order; a channel at its interval rolls over and, if on, sends.
      for (int i = 0; i < NUM_CH; i++) begin
        d = chan_desc(3'(i));
        if (tick_count[i] == d.period) begin
          tick_count[i] = '0;
          rollovers[i]++;
          if (chan_on[i]) begin
            rec = '0;
            rec.ch = 3'(i);
            if (3'(i) == UART_CH) begin
              rec.kind = KIND_UART;
              rec.sbyte = gear_code((chan_value[i] >> 1) > 13'(GEAR_TOP) ?
                                    13'(GEAR_TOP) : chan_value[i] >> 1);
            end else begin
              rec.kind = KIND_CAN;
              rec.pgn = d.pgn;
              rec.data = can_data(3'(i));
            end
            step_out.push_back(rec);
          end
        end else begin
          tick_count[i] = tick_count[i] + 10'd1;
        end
      end
    end else if (lvl == LVL_PRESS && id >= BTN_NEXT && id <= BTN_TOGGLE) begin
      s = sel_ch;
      d = chan_desc(s);
      case (id)
        BTN_NEXT: begin
          s = (int'(sel_ch) + 1 >= NUM_CH) ? 3'd0 : sel_ch + 3'd1;
          sel_ch = s;
        end
        BTN_DEC: begin
          if (chan_value[s] > d.lo_h)
            chan_value[s] = (14'(chan_value[s]) >= 14'(d.lo_h) + 14'(d.stride)) ?
                            chan_value[s] - 13'(d.stride) : d.lo_h;
        end
        BTN_INC: begin
          if (chan_value[s] < d.hi_h) begin
            sum = 14'(chan_value[s]) + 14'(d.stride);
            chan_value[s] = (sum > 14'(d.hi_h)) ? d.hi_h : sum[12:0];
          end
        end
        default: chan_on[s] = ~chan_on[s];
      endcase
      rec = '0;
      rec.kind = KIND_STATUS;
      rec.ch = s;
      rec.halves = chan_value[s];
      rec.en = chan_on[s];
      step_out.push_back(rec);
    end
    // Mark the final result of this event.
    if (step_out.size() != 0) begin
      rec = step_out.pop_back();
      rec.last = 1'b1;
      step_out.push_back(rec);
    end
  endfunction

  function automatic stim_row_t make_row(input logic op, input logic [3:0] id,
                                         input logic lvl);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.id = id;
    r.lvl = lvl;
    return r;
  endfunction

  // Sender pacing: mostly short bursts with gaps, now and then a long stretch with none.
  function automatic void pick_burst();
    if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(60, 200);
    else burst_left = $urandom_range(1, 12);
    gap_len = $urandom_range(1, 9);
  endfunction

  // Present one item, hold it until the transfer, then score it in the model.
  task automatic send_item(input stim_row_t row);
    out_rec_t typed_rec;
    // Present nothing more once the item budget is spent.
    if (n_items >= NUM_ITEMS) return;
    operation <= row.op;
    button_id <= row.id;
    button_level <= row.lvl;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    n_items++;
    if (row.op == OP_TICK) n_ticks++;
    else if (row.lvl == LVL_PRESS && row.id >= BTN_NEXT && row.id <= BTN_TOGGLE) n_presses++;
    schedule_event(row.op, row.id, row.lvl);
    if (row.typed) begin
      // The model still advances; the typed row supplies what is owed.
      if (row.status_due) begin
        typed_rec = '0;
        typed_rec.kind = KIND_STATUS;
        typed_rec.ch = row.ch;
        typed_rec.halves = row.halves;
        typed_rec.en = row.en;
        typed_rec.last = 1'b1;
        due_outputs.push_back(typed_rec);
      end
    end else begin
      foreach (step_out[k]) due_outputs.push_back(step_out[k]);
    end
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
      pick_burst();
    end
  endtask

  task automatic report_fault(input string what, input out_rec_t want, input out_rec_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d ch=%0d pgn=%h data=%h byte=%h halves=%0d en=%b last=%b",
               want.kind, want.ch, want.pgn, want.data, want.sbyte, want.halves, want.en,
               want.last);
      $display("  actual   kind=%0d ch=%0d pgn=%h data=%h byte=%h halves=%0d en=%b last=%b",
               got.kind, got.ch, got.pgn, got.data, got.sbyte, got.halves, got.en, got.last);
    end
  endtask

  // Receiver: stall on its own schedule, switching between free flow, coin flips and a
  // sparse one-in-five ready.
  initial begin : result_sink
    stall_mode_t mode;
    int          span;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 300);
      for (int c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          FLOW_FREE: out_ready <= 1'b1;
          FLOW_COIN: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= (c % 5 == 0);
        endcase
      end
    end
  end

  // Check every output transfer against the oldest owed result, field by field.
  always @(posedge clk) begin : result_check
    out_rec_t got;
    out_rec_t want;
    string    wrong;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.kind = result_kind;
      got.ch = channel_index;
      got.pgn = group_number;
      got.data = frame_payload;
      got.sbyte = serial_byte;
      got.halves = value_halves;
      got.en = enabled_flag;
      got.last = last_of_run;
      if (due_outputs.size() == 0) begin
        report_fault("result with nothing owed", '0, got);
      end else begin
        want = due_outputs.pop_front();
        wrong = "";
        if (got.kind !== want.kind) wrong = {wrong, " kind"};
        if (got.ch !== want.ch) wrong = {wrong, " channel"};
        if (got.pgn !== want.pgn) wrong = {wrong, " pgn"};
        if (got.data !== want.data) wrong = {wrong, " payload"};
        if (got.sbyte !== want.sbyte) wrong = {wrong, " serial"};
        if (got.halves !== want.halves) wrong = {wrong, " value"};
        if (got.en !== want.en) wrong = {wrong, " enable"};
        if (got.last !== want.last) wrong = {wrong, " last"};
        if (wrong != "") report_fault({"mismatch on", wrong}, want, got);
        case (want.kind)
          KIND_CAN:  n_can++;
          KIND_UART: n_uart++;
          default:   n_status++;
        endcase
      end
    end
  end

  initial begin : stimulus
    int         lowest;
    int         waited;
    int         hops;
    logic [3:0] dir;
    reset_scheduler();
    pick_burst();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the table.
    for (int r = 0; r < NUM_DIRECTED; r++) send_item(directed_rows[r]);

    // Random part: tick runs, well-formed button sequences and some noise, until the item
    // budget is spent.
    while (n_items < NUM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          // Run of ticks; button fields carry junk the block should ignore.
          repeat ($urandom_range(1, 120))
            send_item(make_row(OP_TICK, 4'($urandom), 1'($urandom)));
        end
        9, 10, 11, 12, 13, 14, 15, 16: begin
          // Select a channel, then step it one way; long runs push into the limits.
          hops = $urandom_range(0, NUM_CH - 1);
          repeat (hops) begin
            send_item(make_row(OP_BUTTON, BTN_NEXT, LVL_PRESS));
            if ($urandom_range(0, 3) == 0)
              send_item(make_row(OP_BUTTON, BTN_NEXT, LVL_RELEASE));
          end
          dir = ($urandom_range(0, 1) != 0) ? BTN_INC : BTN_DEC;
          repeat (($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20))
            send_item(make_row(OP_BUTTON, dir,
                               ($urandom_range(0, 4) != 0) ? LVL_PRESS : LVL_RELEASE));
          if ($urandom_range(0, 5) == 0)
            send_item(make_row(OP_BUTTON, BTN_TOGGLE, LVL_PRESS));
        end
        default: begin
          // Noise: any field value at all.
          repeat ($urandom_range(1, 4))
            send_item(make_row(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1))));
        end
      endcase
    end

    // Drop valid if the last burst left it up, then drain what is still owed.
    if (burst_left != 0) in_valid <= 1'b0;
    waited = 0;
    while (due_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_outputs.size() != 0) begin
      $display("%0d owed results never arrived", due_outputs.size());
      errors += due_outputs.size();
    end

    lowest = rollovers[0];
    foreach (rollovers[i]) if (rollovers[i] < lowest) lowest = rollovers[i];
    $display("Run covered %0d transfers in: %0d ticks, %0d button presses; fewest rollovers %0d",
             n_items, n_ticks, n_presses, lowest);
    $display("Checked %0d CAN frames, %0d UART bytes, %0d status results; %0d faults",
             n_can, n_uart, n_status, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/pcfs_pkg.sv
hdl/pcfs_frame.sv
hdl/periodic_can_frame_scheduler.sv
verif/tb_periodic_can_frame_scheduler.sv
